### hw/rtl/hsm_pkg.sv
// Shared types and constants for the health score monitor.
package hsm_pkg;

    typedef enum logic
    {
        OP_SIGNAL = 1'b0,
        OP_SAMPLE = 1'b1
    } opcode_t;

    typedef enum logic
    {
        REG_WARN = 1'b0,
        REG_CRIT = 1'b1
    } reg_index_t;

    typedef enum logic [1:0]
    {
        STATUS_STABLE   = 2'd0,
        STATUS_WARNING  = 2'd1,
        STATUS_CRITICAL = 2'd2
    } status_t;

    typedef logic [6:0] score_t;

    typedef struct packed
    {
        score_t signal;
        score_t memory;
        score_t timing;
    } score_set_t;

    localparam score_t           ScoreFull  = 7'd100;
    localparam score_t           WarnReset  = 7'd60;
    localparam score_t           CritReset  = 7'd30;
    localparam logic signed [7:0] SigGood   = -8'sd60;
    localparam logic signed [7:0] SigBad    = -8'sd90;
    localparam logic [23:0]      MemGood    = 24'd80000;
    localparam logic [23:0]      MemBad     = 24'd30000;
    localparam logic [15:0]      TimeGood   = 16'd2;
    localparam logic [15:0]      TimeBad    = 16'd20;

endpackage

### hw/rtl/hsm_if.sv
// Valid/ready channel interfaces for sample beats and result beats.
interface hsm_in_if;
    logic              valid;
    logic              ready;
    logic              opcode;
    logic signed [7:0] signal_dbm;
    logic [23:0]       heap_free;
    logic [15:0]       loop_ms;

    modport source (output valid, output opcode, output signal_dbm, output heap_free,
                    output loop_ms, input ready);
    modport sink (input valid, input opcode, input signal_dbm, input heap_free,
                  input loop_ms, output ready);
endinterface

interface hsm_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] score_signal;
    logic [6:0] score_memory;
    logic [6:0] score_timing;
    logic [6:0] composite;
    logic [1:0] status;
    logic       warning_event;

    modport source (output valid, output score_signal, output score_memory,
                    output score_timing, output composite, output status,
                    output warning_event, input ready);
    modport sink (input valid, input score_signal, input score_memory,
                  input score_timing, input composite, input status,
                  input warning_event, output ready);
endinterface

### hw/rtl/hsm_subscore.sv
// Piecewise-linear sub-scores for signal strength, free heap and loop time.
module hsm_subscore
(
    input  logic signed [7:0]  signal_dbm,
    input  logic [23:0]        heap_free,
    input  logic [15:0]        loop_ms,
    output hsm_pkg::score_set_t scores
);
    import hsm_pkg::*;

    logic signed [8:0] sig_wide;
    logic [4:0]        sig_ofs;
    logic [17:0]       sig_prod;
    logic [23:0]       mem_diff;
    logic [13:0]       mem_quarter;
    logic [27:0]       mem_prod;
    logic [4:0]        time_ofs;
    logic [19:0]       time_prod;

    // floor(x*10/3) = (x*6830)>>11 for x < 30
    assign sig_wide = {signal_dbm[7], signal_dbm} + 9'sd90;
    assign sig_ofs  = sig_wide[4:0];
    assign sig_prod = 18'(sig_ofs) * 18'd6830;

    // floor(d/500) = ((d>>2)*16778)>>21 for d < 50000
    assign mem_diff    = heap_free - MemBad;
    assign mem_quarter = mem_diff[15:2];
    assign mem_prod    = 28'(mem_quarter) * 28'd16778;

    // floor(a*50/9) = (a*45550)>>13 for a < 18
    assign time_ofs  = 5'd20 - loop_ms[4:0];
    assign time_prod = 20'(time_ofs) * 20'd45550;

    always_comb
    begin
        if (signal_dbm <= SigBad)
        begin
            scores.signal = '0;
        end
        else if (signal_dbm >= SigGood)
        begin
            scores.signal = ScoreFull;
        end
        else
        begin
            scores.signal = sig_prod[17:11];
        end

        if (heap_free <= MemBad)
        begin
            scores.memory = '0;
        end
        else if (heap_free >= MemGood)
        begin
            scores.memory = ScoreFull;
        end
        else
        begin
            scores.memory = mem_prod[27:21];
        end

        if (loop_ms >= TimeBad)
        begin
            scores.timing = '0;
        end
        else if (loop_ms <= TimeGood)
        begin
            scores.timing = ScoreFull;
        end
        else
        begin
            scores.timing = time_prod[19:13];
        end
    end

endmodule

### hw/rtl/health_score_monitor_unit.sv
// Health score monitor top level: three-register pipeline from sample to result.
//
// Input channel in_ch carries one beat per item. An opcode-0 beat records the
// signal strength and produces nothing; an opcode-1 beat evaluates a sample
// against the most recent signal strength and produces one beat on out_ch.
// The config port (cfg_we, cfg_index, cfg_data) writes warn_threshold (index
// 0) and crit_threshold (index 1); write only while the pipeline is empty.
//
// Pipeline: a sample accepted on in_ch passes through the input register, the
// sub-score register and the result register before it is presented on out_ch.
// Throughput is one beat per cycle while out_ch is ready; the reciprocal
// multipliers for the constant divisions each sit between two registers.
//
// Reset clears all valid flags, restores the thresholds to 60 and 30, the
// stored signal strength to -60 dBm and re-arms the warning event.
// When out_ch stalls, the result register holds and the stages behind it keep
// filling; in_ch.ready drops only once all three stages hold a sample.
module health_score_monitor_unit
(
    input  logic       clk,
    input  logic       rst_n,
    hsm_in_if.sink     in_ch,
    hsm_out_if.source  out_ch,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [6:0] cfg_data
);
    import hsm_pkg::*;

    score_t            warn_reg;
    score_t            crit_reg;
    logic signed [7:0] last_signal_reg;
    logic              warning_sent_reg;
    logic              warning_sent_next;

    logic              s1_valid_reg;
    logic signed [7:0] s1_rssi_reg;
    logic [23:0]       s1_heap_reg;
    logic [15:0]       s1_loop_reg;

    logic              s2_valid_reg;
    score_set_t        s2_scores_reg;
    score_set_t        sub_scores;

    logic              out_valid_reg;
    score_set_t        out_scores_reg;
    score_t            out_comp_reg;
    status_t           out_status_reg;
    logic              out_event_reg;

    logic              out_free;
    logic              s2_free;
    logic              s1_free;
    logic              in_fire;

    logic [9:0]        comp_sum;
    logic [19:0]       comp_prod;
    score_t            comp_val;
    status_t           status_next;
    logic              event_next;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_fire  = in_ch.valid && s1_free;

    assign in_ch.ready = s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warn_reg <= WarnReset;
            crit_reg <= CritReset;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_WARN: warn_reg <= cfg_data;
                REG_CRIT: crit_reg <= cfg_data;
                default:  warn_reg <= warn_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_signal_reg <= SigGood;
        end
        else if (in_fire && opcode_t'(in_ch.opcode) == OP_SIGNAL)
        begin
            last_signal_reg <= in_ch.signal_dbm;
        end
    end

    // stage 1: sample capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= in_fire && opcode_t'(in_ch.opcode) == OP_SAMPLE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_rssi_reg <= last_signal_reg;
            s1_heap_reg <= in_ch.heap_free;
            s1_loop_reg <= in_ch.loop_ms;
        end
    end

    hsm_subscore u_subscore
    (
        .signal_dbm (s1_rssi_reg),
        .heap_free  (s1_heap_reg),
        .loop_ms    (s1_loop_reg),
        .scores     (sub_scores)
    );

    // stage 2: sub-scores
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_free && s1_valid_reg)
        begin
            s2_scores_reg <= sub_scores;
        end
    end

    // floor(sum/10) = (sum*820)>>13 for sum <= 1000
    assign comp_sum  = {2'b00, s2_scores_reg.signal, 1'b0}
                     + {1'b0, s2_scores_reg.memory, 2'b00}
                     + {1'b0, s2_scores_reg.timing, 2'b00};
    assign comp_prod = 20'(comp_sum) * 20'd820;
    assign comp_val  = comp_prod[19:13];

    always_comb
    begin
        if (comp_val >= warn_reg)
        begin
            status_next = STATUS_STABLE;
        end
        else if (comp_val >= crit_reg)
        begin
            status_next = STATUS_WARNING;
        end
        else
        begin
            status_next = STATUS_CRITICAL;
        end

        event_next        = (status_next != STATUS_STABLE) && !warning_sent_reg;
        warning_sent_next = (status_next != STATUS_STABLE);
    end

    // stage 3: result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            warning_sent_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s2_valid_reg;
            if (s2_valid_reg)
            begin
                warning_sent_reg <= warning_sent_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s2_valid_reg)
        begin
            out_scores_reg <= s2_scores_reg;
            out_comp_reg   <= comp_val;
            out_status_reg <= status_next;
            out_event_reg  <= event_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.score_signal  = out_scores_reg.signal;
    assign out_ch.score_memory  = out_scores_reg.memory;
    assign out_ch.score_timing  = out_scores_reg.timing;
    assign out_ch.composite     = out_comp_reg;
    assign out_ch.status        = out_status_reg;
    assign out_ch.warning_event = out_event_reg;

endmodule
